// ----- rtl/core/dqs_pkg.sv -----
// ---------------------------------------------------------------------------
// Deque search unit package
// Shared types, operation codes and sizes for the bounded deque with a
// front-to-back membership search.
// ---------------------------------------------------------------------------
package dqs_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int FILL_W        = 5;
   localparam int VALUE_W       = 32;

   // Operation codes carried in the func field of a request.
   localparam logic [1:0] FUNC_PUSH_TAIL = 2'd0;
   localparam logic [1:0] FUNC_PUSH_HEAD = 2'd1;
   localparam logic [1:0] FUNC_SEARCH    = 2'd2;
   localparam logic [1:0] FUNC_CLEAR     = 2'd3;

   typedef struct packed {
      logic [1:0]                func;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic              found;
      logic              is_empty;
      logic [FILL_W-1:0] fill_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic push_tail;
      logic push_head;
      logic clear;
      logic search_run;
      logic finish;
      logic found;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] func;
      logic       empty;
      logic       hit;
      logic       exhausted;
   } status_type;

endpackage

// ----- rtl/core/dqs_datapath.sv -----
// ---------------------------------------------------------------------------
// Deque search datapath
// Ring store, head and count registers, search read port and comparator,
// and the registered result.
// ---------------------------------------------------------------------------
module dqs_datapath #(
   parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dqs_pkg::req_type     req_data,
   input  dqs_pkg::cmd_type     cmd,
   output dqs_pkg::status_type  status,
   output dqs_pkg::rsp_type     rsp_data
);
   import dqs_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic signed [VALUE_W-1:0] mem [DEPTH];

   logic [1:0]                func_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          offset_ff;
   logic                      rd_vld_ff;
   logic signed [VALUE_W-1:0] rd_data_ff;
   rsp_type                   rsp_ff;

   logic             full;
   logic             push_ok;
   logic [SUM_W-1:0] tail_sum;
   logic [SUM_W-1:0] rd_sum;
   logic [IDX_W-1:0] tail_addr;
   logic [IDX_W-1:0] head_dec;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_issue;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign push_ok  = (cmd.push_tail || cmd.push_head) && !full;
   assign rd_issue = cmd.search_run && (offset_ff < count_ff);

   // Ring positions: the sums stay below twice the depth, so one subtract folds them.
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_addr = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(tail_sum);
   assign rd_sum    = SUM_W'(head_ff) + SUM_W'(offset_ff);
   assign rd_addr   = (rd_sum >= SUM_W'(DEPTH)) ? IDX_W'(rd_sum - SUM_W'(DEPTH))
                                                : IDX_W'(rd_sum);
   assign head_dec  = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (push_ok) begin
         count_in = count_ff + CNT_W'(1);
         if (cmd.push_head) begin
            head_in = head_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         offset_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (cmd.load) begin
            offset_ff <= '0;
            rd_vld_ff <= 1'b0;
         end else if (cmd.search_run) begin
            rd_vld_ff <= rd_issue;
            if (rd_issue) begin
               offset_ff <= offset_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_data.func;
         value_ff <= req_data.value;
      end
   end

   // Single write port and a registered read port.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[cmd.push_head ? head_dec : tail_addr] <= value_ff;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.accepted   <= !((cmd.push_tail || cmd.push_head) && full);
         rsp_ff.found      <= cmd.found;
         rsp_ff.is_empty   <= (count_in == '0);
         rsp_ff.fill_count <= FILL_W'(count_in);
      end
   end

   assign status.func      = func_ff;
   assign status.empty     = (count_ff == '0);
   assign status.hit       = rd_vld_ff && (rd_data_ff == value_ff);
   assign status.exhausted = rd_vld_ff && (offset_ff == count_ff);
   assign rsp_data         = rsp_ff;

endmodule

// ----- rtl/core/dqs_controller.sv -----
// ---------------------------------------------------------------------------
// Deque search controller
// Sequences each request: decode, the search loop, and the result strobe.
// ---------------------------------------------------------------------------
module dqs_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  dqs_pkg::status_type status,
   output dqs_pkg::cmd_type    cmd,
   output logic                rsp_strobe
);
   import dqs_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (status.func)
               FUNC_PUSH_TAIL: begin
                  cmd.push_tail = 1'b1;
                  cmd.finish    = 1'b1;
                  state_in      = S_IDLE;
               end
               FUNC_PUSH_HEAD: begin
                  cmd.push_head = 1'b1;
                  cmd.finish    = 1'b1;
                  state_in      = S_IDLE;
               end
               FUNC_SEARCH: begin
                  if (status.empty) begin
                     cmd.finish = 1'b1;
                     state_in   = S_IDLE;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end
               default: begin
                  cmd.clear  = 1'b1;
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_SEARCH: begin
            cmd.search_run = 1'b1;
            // Stop on the first match, or once the last held entry has been compared.
            if (status.hit || status.exhausted) begin
               cmd.finish = 1'b1;
               cmd.found  = status.hit;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.finish;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// ----- rtl/core/deque_with_membership_search_unit.sv -----
// A push or clear runs in the execute state, then its result strobe is registered;
// a search over n held entries reads them in turn, stopping early on a match.
// A new request is taken in the cycle its predecessor's result is shown,
// and a search is bounded by the one-read-a-cycle store.
// Reset clears the head and count registers; store contents are undefined until pushed.
// The receiver cannot stall: each result is presented for exactly one cycle.
// ---------------------------------------------------------------------------
// Deque with membership search, top level
// Bounded double-ended queue of signed values in a ring store, with a
// front-to-back linear search; one result per request.
// ---------------------------------------------------------------------------
module deque_with_membership_search_unit #(
   parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dqs_pkg::req_type req_data,
   output logic             rsp_strobe,
   output dqs_pkg::rsp_type rsp_data
);
   import dqs_pkg::*;

   cmd_type    cmd;
   status_type status;

   dqs_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .status     (status),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   dqs_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a start transfer");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result strobes in consecutive cycles");

   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.is_empty == (rsp_data.fill_count == '0)))
      else $error("is_empty disagrees with fill_count");

   a_reject_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.accepted) |-> !rsp_data.found)
      else $error("rejected push reported a match");

endmodule
